// File: design/c2p_pkg.sv
// Shared types, constants and the arctangent table of the sighting converter.
// Used by c2p_stage, cartesian_to_polar_with_time and c2p_checker.

package c2p_pkg;

   // Field widths of the transfer payloads
   localparam int TIME_W       = 14;
   localparam int COORD_WIDTH  = 16;
   localparam int MOD_W        = 11;
   localparam int DIST_W       = 16;
   localparam int HEAD_W       = 16;

   // Time of day
   localparam int HHMM_BASE     = 100;
   localparam int MINS_PER_HOUR = 60;
   localparam int HOURS_MAX     = 23;
   localparam int MINS_MAX      = 59;
   localparam int HOURS_W       = 8;
   localparam int MINS_W        = 7;
   // floor(t / 100) == (t * 5243) >> 19 for every 14-bit t
   localparam int DIV100_MUL    = 5243;
   localparam int DIV100_SHIFT  = 19;
   localparam int PROD_W        = 27;

   // Distance: restoring square root, one result bit per stage
   localparam int SUM_W        = 2 * COORD_WIDTH;
   localparam int SQRT_STEPS   = COORD_WIDTH;
   localparam int DIST_MAX     = (1 << DIST_W) - 1;

   // Heading: vectoring rotations on coordinates scaled by 2^GUARD_BITS
   localparam int GUARD_BITS      = 16;
   localparam int CORD_W          = COORD_WIDTH + GUARD_BITS + 3;
   localparam int ACC_W           = 27;
   localparam int ATAN_ENTRIES    = 24;
   localparam int ATAN_IDX_W      = 5;
   localparam int HALF_TURN_DEG   = 180;
   localparam int ACC_FRAC        = 16;
   localparam int HEADING_ROUND   = 256;
   localparam int HEADING_SHIFT   = 9;
   localparam int HEADING_LIMIT   = 23040;

   localparam int CORDIC_STEPS_DEF = 16;

   typedef struct packed {
      logic [TIME_W-1:0]             time_hhmm;
      logic signed [COORD_WIDTH-1:0] x_pos;
      logic signed [COORD_WIDTH-1:0] y_pos;
   } c2p_req_type;

   typedef struct packed {
      logic [MOD_W-1:0]         minutes_of_day;
      logic                     time_valid;
      logic [DIST_W-1:0]        distance;
      logic signed [HEAD_W-1:0] heading;
   } c2p_rsp_type;

   // Everything one item carries down the pipeline
   typedef struct packed {
      logic [TIME_W-1:0]        time_hhmm;
      logic [PROD_W-1:0]        quot_prod;
      logic [HOURS_W-1:0]       hours;
      logic [MINS_W-1:0]        minutes;
      logic [MOD_W-1:0]         minutes_of_day;
      logic                     time_valid;
      logic [SUM_W-1:0]         x_sq;
      logic [SUM_W-1:0]         y_sq;
      logic [SUM_W-1:0]         rem;
      logic [SUM_W-1:0]         root;
      logic signed [CORD_W-1:0] cx;
      logic signed [CORD_W-1:0] cy;
      logic signed [ACC_W-1:0]  acc;
      logic                     at_origin;
      logic [DIST_W-1:0]        distance;
      logic signed [HEAD_W-1:0] heading;
   } c2p_lane_type;

   // atan(2^-i) in degrees scaled by 2^16, rounded to nearest
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = ACC_W'(2949120);
         5'd1:    val = ACC_W'(1740967);
         5'd2:    val = ACC_W'(919879);
         5'd3:    val = ACC_W'(466945);
         5'd4:    val = ACC_W'(234379);
         5'd5:    val = ACC_W'(117304);
         5'd6:    val = ACC_W'(58666);
         5'd7:    val = ACC_W'(29335);
         5'd8:    val = ACC_W'(14668);
         5'd9:    val = ACC_W'(7334);
         5'd10:   val = ACC_W'(3667);
         5'd11:   val = ACC_W'(1833);
         5'd12:   val = ACC_W'(917);
         5'd13:   val = ACC_W'(458);
         5'd14:   val = ACC_W'(229);
         5'd15:   val = ACC_W'(115);
         5'd16:   val = ACC_W'(57);
         5'd17:   val = ACC_W'(29);
         5'd18:   val = ACC_W'(14);
         5'd19:   val = ACC_W'(7);
         5'd20:   val = ACC_W'(4);
         5'd21:   val = ACC_W'(2);
         5'd22:   val = ACC_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: design/cartesian_to_polar_with_time.sv
// Sighting converter top level: HHMM time to minutes, (x, y) to distance and
// heading through a pipeline of c2p_stage instances. Depends on c2p_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  c2p_req_type: time_hhmm, x_pos, y_pos
//   rsp      out        rsp_valid / rsp_ready  c2p_rsp_type: minutes_of_day, time_valid,
//                                              distance, heading
//
// One transfer in per cycle unless stalled, one result per transfer, in order.
// Stages: prep, then one stage per rotation of the angle path or, after a root
// setup stage, one per root bit of the distance path, then final rounding.
// The longer of the two paths sets the depth.
// Reset clears the stage valid bits only; the lane data registers are not reset.
// Stalls: a stage loads whenever it is empty or the stage after it moves, so
// bubbles close up; req_ready drops only once every stage holds an item while
// rsp_ready is low, and it follows rsp_ready combinationally through the stages.

module cartesian_to_polar_with_time #(
   parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  c2p_pkg::c2p_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output c2p_pkg::c2p_rsp_type rsp_data
);

   // Limit rotations to the table
   localparam int STEPS     = (CORDIC_STEPS > c2p_pkg::ATAN_ENTRIES) ?
                              c2p_pkg::ATAN_ENTRIES : CORDIC_STEPS;
   // Last stage of either iterative path; the root starts one stage later
   localparam int LAST_ITER = (STEPS > c2p_pkg::SQRT_STEPS + 1) ?
                              STEPS : (c2p_pkg::SQRT_STEPS + 1);
   localparam int DEPTH     = LAST_ITER + 2;

   logic [DEPTH:0]        stage_en;
   logic [DEPTH-1:0]      stage_valid;
   c2p_pkg::c2p_lane_type stage_lane [DEPTH];
   c2p_pkg::c2p_lane_type front_lane;

   // Raw coordinates ride in the rotation fields until the prep stage
   always_comb begin
      front_lane           = '0;
      front_lane.time_hhmm = req_data.time_hhmm;
      front_lane.cx        = c2p_pkg::CORD_W'(req_data.x_pos);
      front_lane.cy        = c2p_pkg::CORD_W'(req_data.y_pos);
   end

   // Advance a stage when it is empty or its successor advances
   assign stage_en[DEPTH] = rsp_ready;

   for (genvar k = 0; k < DEPTH; k++) begin : g_stage
      assign stage_en[k] = !stage_valid[k] || stage_en[k+1];

      if (k == 0) begin : g_head
         c2p_stage #(
            .STAGE       (k),
            .STEPS       (STEPS),
            .FINAL_STAGE (DEPTH - 1)
         ) u_stage (
            .clock       (clock),
            .reset       (reset),
            .en          (stage_en[k]),
            .in_valid    (req_valid),
            .in_lane     (front_lane),
            .stage_valid (stage_valid[k]),
            .stage_lane  (stage_lane[k])
         );
      end else begin : g_body
         c2p_stage #(
            .STAGE       (k),
            .STEPS       (STEPS),
            .FINAL_STAGE (DEPTH - 1)
         ) u_stage (
            .clock       (clock),
            .reset       (reset),
            .en          (stage_en[k]),
            .in_valid    (stage_valid[k-1]),
            .in_lane     (stage_lane[k-1]),
            .stage_valid (stage_valid[k]),
            .stage_lane  (stage_lane[k])
         );
      end
   end

   assign req_ready = stage_en[0];

   // The last stage is the output register
   assign rsp_valid               = stage_valid[DEPTH-1];
   assign rsp_data.minutes_of_day = stage_lane[DEPTH-1].minutes_of_day;
   assign rsp_data.time_valid     = stage_lane[DEPTH-1].time_valid;
   assign rsp_data.distance       = stage_lane[DEPTH-1].distance;
   assign rsp_data.heading        = stage_lane[DEPTH-1].heading;

endmodule

// File: design/c2p_stage.sv
// One register stage of the sighting converter pipeline: the work assigned to
// stage STAGE (prep, time lane, one root bit, one rotation, final rounding).
// Depends on c2p_pkg.

module c2p_stage #(
   parameter int STAGE       = 0,
   parameter int STEPS       = c2p_pkg::CORDIC_STEPS_DEF,
   parameter int FINAL_STAGE = c2p_pkg::CORDIC_STEPS_DEF + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  c2p_pkg::c2p_lane_type in_lane,
   output logic                  stage_valid,
   output c2p_pkg::c2p_lane_type stage_lane
);

   localparam bit SQ_ACTIVE = (STAGE >= 2) && (STAGE < 2 + c2p_pkg::SQRT_STEPS);
   localparam int SQ_SHIFT  = SQ_ACTIVE ? (c2p_pkg::SUM_W - 2 - 2 * (STAGE - 2)) : 0;
   localparam bit CR_ACTIVE = (STAGE >= 1) && (STAGE <= STEPS);
   localparam int CR_IDX    = CR_ACTIVE ? (STAGE - 1) : 0;

   logic                                  valid_ff;
   c2p_pkg::c2p_lane_type                 lane_ff;
   c2p_pkg::c2p_lane_type                 lane_in;

   logic signed [c2p_pkg::COORD_WIDTH-1:0] x_raw;
   logic signed [c2p_pkg::COORD_WIDTH-1:0] y_raw;
   logic signed [c2p_pkg::SUM_W-1:0]       x_sq_s;
   logic signed [c2p_pkg::SUM_W-1:0]       y_sq_s;
   logic signed [c2p_pkg::CORD_W-1:0]      x_scaled;
   logic signed [c2p_pkg::CORD_W-1:0]      y_scaled;
   logic signed [c2p_pkg::CORD_W-1:0]      x_shr;
   logic signed [c2p_pkg::CORD_W-1:0]      y_shr;
   logic signed [c2p_pkg::ACC_W-1:0]       angle;
   logic [c2p_pkg::TIME_W-1:0]             hundreds;
   logic [c2p_pkg::TIME_W-1:0]             mins_diff;
   logic                                   ok;
   logic [c2p_pkg::SUM_W-1:0]              sq_bit;
   logic [c2p_pkg::SUM_W-1:0]              trial;
   logic [c2p_pkg::SQRT_STEPS:0]           rounded;
   logic signed [c2p_pkg::ACC_W-1:0]       head_q;

   always_comb begin
      lane_in   = in_lane;
      x_raw     = in_lane.cx[c2p_pkg::COORD_WIDTH-1:0];
      y_raw     = in_lane.cy[c2p_pkg::COORD_WIDTH-1:0];
      x_sq_s    = c2p_pkg::SUM_W'(x_raw) * c2p_pkg::SUM_W'(x_raw);
      y_sq_s    = c2p_pkg::SUM_W'(y_raw) * c2p_pkg::SUM_W'(y_raw);
      x_scaled  = c2p_pkg::CORD_W'(x_raw) <<< c2p_pkg::GUARD_BITS;
      y_scaled  = c2p_pkg::CORD_W'(y_raw) <<< c2p_pkg::GUARD_BITS;
      x_shr     = in_lane.cx >>> CR_IDX;
      y_shr     = in_lane.cy >>> CR_IDX;
      angle     = c2p_pkg::atan_entry(c2p_pkg::ATAN_IDX_W'(CR_IDX));
      hundreds  = c2p_pkg::TIME_W'(in_lane.hours) * c2p_pkg::TIME_W'(c2p_pkg::HHMM_BASE);
      mins_diff = in_lane.time_hhmm - hundreds;
      ok        = (in_lane.hours <= c2p_pkg::HOURS_W'(c2p_pkg::HOURS_MAX)) &&
                  (in_lane.minutes <= c2p_pkg::MINS_W'(c2p_pkg::MINS_MAX));
      sq_bit    = c2p_pkg::SUM_W'(1) << SQ_SHIFT;
      trial     = in_lane.root + sq_bit;
      rounded   = in_lane.root[c2p_pkg::SQRT_STEPS:0] +
                  (c2p_pkg::SQRT_STEPS+1)'(in_lane.rem > in_lane.root);
      head_q    = (in_lane.acc + c2p_pkg::ACC_W'(c2p_pkg::HEADING_ROUND))
                  >>> c2p_pkg::HEADING_SHIFT;

      // Prep: squares, quotient product, scale and fold into the right half plane
      if (STAGE == 0) begin
         lane_in.quot_prod = c2p_pkg::PROD_W'(in_lane.time_hhmm) *
                             c2p_pkg::PROD_W'(c2p_pkg::DIV100_MUL);
         lane_in.x_sq      = c2p_pkg::SUM_W'(x_sq_s);
         lane_in.y_sq      = c2p_pkg::SUM_W'(y_sq_s);
         lane_in.at_origin = (x_raw == '0) && (y_raw == '0);
         if (x_raw < 0) begin
            lane_in.cx  = -x_scaled;
            lane_in.cy  = -y_scaled;
            lane_in.acc = (y_raw >= 0) ?
               c2p_pkg::ACC_W'(c2p_pkg::HALF_TURN_DEG << c2p_pkg::ACC_FRAC) :
               -c2p_pkg::ACC_W'(c2p_pkg::HALF_TURN_DEG << c2p_pkg::ACC_FRAC);
         end else begin
            lane_in.cx  = x_scaled;
            lane_in.cy  = y_scaled;
            lane_in.acc = '0;
         end
      end

      if (STAGE == 1) begin
         lane_in.hours = c2p_pkg::HOURS_W'(in_lane.quot_prod >> c2p_pkg::DIV100_SHIFT);
         lane_in.rem   = in_lane.x_sq + in_lane.y_sq;
         lane_in.root  = '0;
      end

      if (STAGE == 2) begin
         lane_in.minutes = mins_diff[c2p_pkg::MINS_W-1:0];
      end

      if (STAGE == 3) begin
         lane_in.time_valid     = ok;
         lane_in.minutes_of_day = ok ?
            (c2p_pkg::MOD_W'(in_lane.hours) * c2p_pkg::MOD_W'(c2p_pkg::MINS_PER_HOUR) +
             c2p_pkg::MOD_W'(in_lane.minutes)) : '0;
      end

      // One bit of the square root
      if (SQ_ACTIVE) begin
         if (in_lane.rem >= trial) begin
            lane_in.rem  = in_lane.rem - trial;
            lane_in.root = (in_lane.root >> 1) + sq_bit;
         end else begin
            lane_in.root = in_lane.root >> 1;
         end
      end

      // One vectoring rotation, driving y toward zero
      if (CR_ACTIVE) begin
         if (!in_lane.cy[c2p_pkg::CORD_W-1]) begin
            lane_in.cx  = in_lane.cx + y_shr;
            lane_in.cy  = in_lane.cy - x_shr;
            lane_in.acc = in_lane.acc + angle;
         end else begin
            lane_in.cx  = in_lane.cx - y_shr;
            lane_in.cy  = in_lane.cy + x_shr;
            lane_in.acc = in_lane.acc - angle;
         end
      end

      // Round the root and the angle, saturate both; the heading is zero at the origin
      if (STAGE == FINAL_STAGE) begin
         if (rounded > (c2p_pkg::SQRT_STEPS+1)'(c2p_pkg::DIST_MAX)) begin
            lane_in.distance = c2p_pkg::DIST_W'(c2p_pkg::DIST_MAX);
         end else begin
            lane_in.distance = c2p_pkg::DIST_W'(rounded);
         end
         if (in_lane.at_origin) begin
            lane_in.heading = '0;
         end else if (head_q > c2p_pkg::ACC_W'(c2p_pkg::HEADING_LIMIT)) begin
            lane_in.heading = c2p_pkg::HEAD_W'(c2p_pkg::HEADING_LIMIT);
         end else if (head_q < -c2p_pkg::ACC_W'(c2p_pkg::HEADING_LIMIT)) begin
            lane_in.heading = -c2p_pkg::HEAD_W'(c2p_pkg::HEADING_LIMIT);
         end else begin
            lane_in.heading = c2p_pkg::HEAD_W'(head_q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_lane  = lane_ff;

endmodule

// File: design/c2p_checker.sv
// Port-level checks for the sighting converter, bound to its top level.
// Depends on c2p_pkg and cartesian_to_polar_with_time.

module c2p_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input c2p_pkg::c2p_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input c2p_pkg::c2p_rsp_type rsp_data
);

   // Drop any result on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_bad_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.time_valid |-> rsp_data.minutes_of_day == '0)
      else $error("invalid time carries nonzero minutes");

   a_minutes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.minutes_of_day <= c2p_pkg::MOD_W'(1439))
      else $error("minutes past end of day");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.heading <= c2p_pkg::HEAD_W'(c2p_pkg::HEADING_LIMIT)) &&
                    (rsp_data.heading >= -c2p_pkg::HEAD_W'(c2p_pkg::HEADING_LIMIT)))
      else $error("heading outside half turn");

endmodule

bind cartesian_to_polar_with_time c2p_checker u_c2p_checker (.*);

// File: tb/sv/cartesian_to_polar_with_time_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the sighting converter: HHMM time, distance and heading.
// Depends on c2p_pkg and cartesian_to_polar_with_time; holds its own bit-exact predictor.

module cartesian_to_polar_with_time_tb;

   // Rotations the block runs at its default setting, capped at the table size
   localparam int N_ROT       = (c2p_pkg::CORDIC_STEPS_DEF > c2p_pkg::ATAN_ENTRIES) ?
                                c2p_pkg::ATAN_ENTRIES : c2p_pkg::CORDIC_STEPS_DEF;
   localparam int N_RANDOM    = 2000;
   localparam int DRAIN_WAIT  = 40;        // pipeline depth is 19 at the defaults
   localparam int STALL_NONE  = 0;
   localparam int STALL_SHORT = 1;
   localparam int STALL_LONG  = 2;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   c2p_pkg::c2p_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   c2p_pkg::c2p_rsp_type rsp_data;

   // Pending sightings for the driver, expected polar results for the monitor
   c2p_pkg::c2p_req_type sighting_q[$];
   c2p_pkg::c2p_rsp_type polar_q[$];

   int   n_total  = 0;
   int   n_taken  = 0;
   int   n_sent   = 0;
   int   n_errors = 0;

   // atan(2^-i) in degrees scaled by 2^16
   longint atan_step_deg16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   cartesian_to_polar_with_time u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Rounded integer square root: largest r with r*r <= s, then bump up
   // when s lies past the midpoint r*r + r.
   function automatic longint rounded_root(input longint s);
      longint r;
      longint cand;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         cand = r | (longint'(1) << b);
         if (cand * cand <= s) r = cand;
      end
      if (s - r * r > r) r = r + 1;
      return r;
   endfunction

   // Vectoring CORDIC on coordinates scaled by 2^16; angle kept in deg * 2^16.
   function automatic longint heading_deg_q7(input longint px, input longint py);
      longint cx, cy, acc, xs, ys, hd;
      if (px == 0 && py == 0) return 0;
      cx  = px * 65536;
      cy  = py * 65536;
      acc = 0;
      // Left half plane: fold onto the right half and start from +/-180 degrees
      if (cx < 0) begin
         acc = (cy >= 0) ? longint'(c2p_pkg::HALF_TURN_DEG) * 65536 :
                           -longint'(c2p_pkg::HALF_TURN_DEG) * 65536;
         cx  = -cx;
         cy  = -cy;
      end
      for (int i = 0; i < N_ROT; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx  = cx + ys;
            cy  = cy - xs;
            acc = acc + atan_step_deg16[i];
         end else begin
            cx  = cx - ys;
            cy  = cy + xs;
            acc = acc - atan_step_deg16[i];
         end
      end
      hd = (acc + c2p_pkg::HEADING_ROUND) >>> c2p_pkg::HEADING_SHIFT;
      if (hd > c2p_pkg::HEADING_LIMIT) hd = c2p_pkg::HEADING_LIMIT;
      if (hd < -c2p_pkg::HEADING_LIMIT) hd = -c2p_pkg::HEADING_LIMIT;
      return hd;
   endfunction

   function automatic c2p_pkg::c2p_rsp_type predict_polar(input c2p_pkg::c2p_req_type s);
      c2p_pkg::c2p_rsp_type p;
      longint               hh, mm, px, py;
      hh = longint'(s.time_hhmm) / c2p_pkg::HHMM_BASE;
      mm = longint'(s.time_hhmm) % c2p_pkg::HHMM_BASE;
      px = longint'($signed(s.x_pos));
      py = longint'($signed(s.y_pos));
      p.time_valid     = (hh <= c2p_pkg::HOURS_MAX) && (mm <= c2p_pkg::MINS_MAX);
      p.minutes_of_day = p.time_valid ?
                         c2p_pkg::MOD_W'(hh * c2p_pkg::MINS_PER_HOUR + mm) : '0;
      p.distance       = c2p_pkg::DIST_W'(rounded_root(px * px + py * py));
      p.heading        = c2p_pkg::HEAD_W'(heading_deg_q7(px, py));
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   task automatic add_sighting(input int t, input int x, input int y);
      c2p_pkg::c2p_req_type s;
      s.time_hhmm = c2p_pkg::TIME_W'(t);
      s.x_pos     = c2p_pkg::COORD_WIDTH'(x);
      s.y_pos     = c2p_pkg::COORD_WIDTH'(y);
      sighting_q.push_back(s);
      n_total++;
   endtask

   function automatic logic signed [c2p_pkg::COORD_WIDTH-1:0] random_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return c2p_pkg::COORD_WIDTH'($urandom);
      if (pick < 7) return c2p_pkg::COORD_WIDTH'($urandom_range(0, 128) - 64);
      if (pick < 8) return c2p_pkg::COORD_WIDTH'($urandom_range(0, 2048) - 1024);
      case ($urandom_range(0, 5))
         0:       return c2p_pkg::COORD_WIDTH'(-32768);
         1:       return c2p_pkg::COORD_WIDTH'(-32767);
         2:       return c2p_pkg::COORD_WIDTH'(-1);
         3:       return c2p_pkg::COORD_WIDTH'(0);
         4:       return c2p_pkg::COORD_WIDTH'(1);
         default: return c2p_pkg::COORD_WIDTH'(32767);
      endcase
   endfunction

   function automatic int random_hhmm();
      int pick;
      pick = $urandom_range(0, 9);
      // mostly real clock times, then any decimal HHMM, then any 14-bit code
      if (pick < 7) return $urandom_range(0, c2p_pkg::HOURS_MAX) * c2p_pkg::HHMM_BASE +
                           $urandom_range(0, c2p_pkg::MINS_MAX);
      if (pick < 9) return $urandom_range(0, 9999);
      return $urandom_range(0, (1 << c2p_pkg::TIME_W) - 1);
   endfunction

   // ------------------------------------------------------------------
   // Driver: feed the queue in bursts, hold each transfer until accepted
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && n_taken != n_sent) begin
         // hold valid and payload until the transfer goes through
      end else begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sighting_q.size() > 0) begin
            req_data  <= sighting_q.pop_front();
            req_valid <= 1'b1;
            n_sent++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // new burst; a quarter of gaps are zero so bursts also run back to back
               burst_left = $urandom_range(1, 32);
               case ($urandom_range(0, 3))
                  0:       gap_left = 0;
                  1, 2:    gap_left = $urandom_range(1, 4);
                  default: gap_left = $urandom_range(5, 30);
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure: modes of free flow, short and long stalls
   // ------------------------------------------------------------------
   int stall_mode = STALL_NONE;
   int mode_left  = 0;
   int run_left   = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
            mode_left  = $urandom_range(64, 512);
            run_left   = 0;
            stall_left = 0;
         end else begin
            mode_left--;
         end
         if (stall_mode == STALL_NONE) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_ready <= 1'b1;
         end else begin
            // reload the pattern; this cycle starts the ready run
            if (stall_mode == STALL_SHORT) begin
               run_left   = $urandom_range(0, 2);
               stall_left = $urandom_range(1, 3);
            end else begin
               run_left   = $urandom_range(0, 1);
               stall_left = $urandom_range(5, 20);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each input transfer, check each result transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      c2p_pkg::c2p_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            polar_q.push_back(predict_polar(req_data));
            n_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (polar_q.size() == 0) begin
               $error("result transfer with nothing expected: minutes_of_day %0d distance %0d",
                      rsp_data.minutes_of_day, rsp_data.distance);
               n_errors++;
            end else begin
               want = polar_q.pop_front();
               if (rsp_data.minutes_of_day !== want.minutes_of_day) begin
                  $error("minutes_of_day: expected %0d, actual %0d",
                         want.minutes_of_day, rsp_data.minutes_of_day);
                  n_errors++;
               end
               if (rsp_data.time_valid !== want.time_valid) begin
                  $error("time_valid: expected %0d, actual %0d",
                         want.time_valid, rsp_data.time_valid);
                  n_errors++;
               end
               if (rsp_data.distance !== want.distance) begin
                  $error("distance: expected %0d, actual %0d",
                         want.distance, rsp_data.distance);
                  n_errors++;
               end
               if (rsp_data.heading !== want.heading) begin
                  $error("heading: expected %0d, actual %0d",
                         $signed(want.heading), $signed(rsp_data.heading));
                  n_errors++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      // Directed: field extremes, invalid times, origin, axes and the
      // negative x axis where the +/-180 start depends on the sign of y
      add_sighting(0,     0,      0);
      add_sighting(2359,  32767,  0);
      add_sighting(2360,  -32768, 0);
      add_sighting(2400,  0,      32767);
      add_sighting(9999,  0,      -32768);
      add_sighting(16383, -32768, -32768);
      add_sighting(1200,  32767,  32767);
      add_sighting(59,    -32768, 32767);
      add_sighting(60,    -1,     0);
      add_sighting(100,   -1,     -1);
      add_sighting(1259,  1,      -1);
      add_sighting(2300,  -5,     0);
      add_sighting(999,   -32768, -1);
      add_sighting(1,     32767,  -32768);
      add_sighting(8192,  1,      0);
      add_sighting(5555,  0,      1);
      add_sighting(1439,  -200,   3);
      add_sighting(2399,  0,      0);
      add_sighting(10,    128,    -128);
      add_sighting(4096,  -32767, 32767);

      for (int i = 0; i < N_RANDOM; i++)
         add_sighting(random_hhmm(), random_coord(), random_coord());

      // Synchronous reset, released on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Drain: every sighting accepted and every result back, then let the
      // pipeline run dry to catch stray results
      do @(negedge clock); while (n_taken != n_total || polar_q.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (polar_q.size() != 0) begin
         $error("%0d expected results never arrived", polar_q.size());
         n_errors++;
      end
      if (n_errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog well beyond the slowest legal run
   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
